// ===== design/ipd_pkg.sv =====
package ipd_pkg;

	localparam int FRAME_BITS_DEF = 32;
	localparam int TIME_WIDTH_DEF = 32;

	localparam int EDGE_W  = 32;
	localparam int WORD_W  = 32;
	localparam int TICKS_W = 16;
	localparam int CIDX_W  = 8;

	localparam logic [TICKS_W-1:0] START_RST = 16'd6800;
	localparam logic [TICKS_W-1:0] ONE_RST   = 16'd1690;
	localparam logic [TICKS_W-1:0] ZERO_RST  = 16'd850;
	localparam logic [TICKS_W-1:0] TOL_RST   = 16'd100;

	typedef enum logic [CIDX_W-1:0] {
		REG_START = 8'd0,
		REG_ONE   = 8'd1,
		REG_ZERO  = 8'd2,
		REG_TOL   = 8'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_EDGE = 1'b0,
		KIND_ACK  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_GOOD = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic              kind;
		logic [EDGE_W-1:0] edge_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] frame_word;
		logic              holding;
	} out_item_t;

	typedef struct packed {
		logic [TICKS_W-1:0] start_ticks;
		logic [TICKS_W-1:0] one_ticks;
		logic [TICKS_W-1:0] zero_ticks;
		logic [TICKS_W-1:0] tolerance_ticks;
	} cfg_t;

endpackage

// ===== design/ipd_core.sv =====
module ipd_core import ipd_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	localparam int CNT_W = $clog2(FRAME_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);

	logic [TIME_WIDTH-1:0] prev_q;
	logic                  in_frame_q;
	logic [CNT_W-1:0]      count_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic                  bad_q;
	logic                  ready_q;

	logic [TIME_WIDTH-1:0] now;
	logic [TIME_WIDTH-1:0] interval;
	logic                  is_start, is_one, is_zero;
	logic                  is_ack, is_edge, do_start, do_bit, do_done;
	logic [FRAME_BITS+WORD_W-1:0] word_ext;

	function automatic logic near_to(input logic [TIME_WIDTH-1:0] iv,
					 input logic [TICKS_W-1:0] nom,
					 input logic [TICKS_W-1:0] tol);
		logic [TIME_WIDTH-1:0] nom_x;
		logic [TIME_WIDTH-1:0] dev;
		nom_x = TIME_WIDTH'(nom);
		dev = (iv > nom_x) ? (iv - nom_x) : (nom_x - iv);
		return dev < TIME_WIDTH'(tol);
	endfunction

	always_comb begin
		now      = TIME_WIDTH'(item.edge_time);
		interval = now - prev_q;
		is_start = near_to(interval, cfg.start_ticks, cfg.tolerance_ticks);
		is_one   = near_to(interval, cfg.one_ticks, cfg.tolerance_ticks);
		is_zero  = near_to(interval, cfg.zero_ticks, cfg.tolerance_ticks);
		is_ack   = (item.kind == KIND_ACK);
		is_edge  = !is_ack && !ready_q;
		do_start = is_edge && is_start;
		do_bit   = is_edge && !is_start && in_frame_q && (count_q < CNT_FULL);
		do_done  = is_edge && !is_start && in_frame_q && (count_q == CNT_FULL);
		word_ext = {{WORD_W{1'b0}}, shift_q};

		result.status     = ST_NONE;
		result.frame_word = '0;
		result.holding    = is_ack ? 1'b0 : (ready_q || do_done);
		if (do_done) begin
			if (bad_q) begin
				result.status = ST_BAD;
			end else begin
				result.status     = ST_GOOD;
				result.frame_word = word_ext[WORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			in_frame_q <= 1'b0;
			count_q    <= '0;
			shift_q    <= '0;
			bad_q      <= 1'b0;
			ready_q    <= 1'b0;
		end else if (en) begin
			if (is_ack) begin
				ready_q <= 1'b0;
			end else if (is_edge) begin
				prev_q <= now;
				if (do_start) begin
					in_frame_q <= 1'b1;
					count_q    <= '0;
					shift_q    <= '0;
					bad_q      <= 1'b0;
				end else if (do_bit) begin
					shift_q <= (shift_q << 1) | FRAME_BITS'(is_one);
					count_q <= count_q + 1'b1;
					if (!is_one && !is_zero) begin
						bad_q <= 1'b1;
					end
				end else if (do_done) begin
					in_frame_q <= 1'b0;
					ready_q    <= 1'b1;
					count_q    <= '0;
				end
			end
		end
	end

endmodule

// ===== design/ir_pulse_distance_decoder.sv =====
// Pulse-distance IR remote frame decoder.
// in channel (in_valid/in_stall/in_data): one request per falling edge
// (kind 0, with the timer count) or per acknowledge of a held frame (kind 1).
// out channel (out_valid/out_stall/out_data): exactly one result per request,
// in order: status (none, good, bad), the frame word when good, and whether a
// completed frame is held awaiting acknowledge. Edges are ignored while held.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the start, one,
// zero and tolerance tick counts; cfg_ready is always high. Write only idle.
// Pipeline: an accepted request sits in the input register; its result is
// then registered in the result register, which drives out_data.
// Throughput: one request per cycle unless a result stalls; the interval
// subtract and three tolerance compares sit between the two registers.
// A stalled result holds; the input register still fills behind it, after
// which in_stall follows out_stall.
// Reset: tick registers return to their defaults, decoder state clears,
// both pipeline registers empty.
module ir_pulse_distance_decoder import ipd_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [TICKS_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t res;
	logic      adv;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_ticks     <= START_RST;
			cfg_q.one_ticks       <= ONE_RST;
			cfg_q.zero_ticks      <= ZERO_RST;
			cfg_q.tolerance_ticks <= TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_START: cfg_q.start_ticks     <= cfg_data;
				REG_ONE:   cfg_q.one_ticks       <= cfg_data;
				REG_ZERO:  cfg_q.zero_ticks      <= cfg_data;
				REG_TOL:   cfg_q.tolerance_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	ipd_core #(
		.FRAME_BITS(FRAME_BITS),
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.item(item_s1),
		.cfg(cfg_q),
		.result(res)
	);

endmodule

// ===== test/tb_ir_pulse_distance_decoder.sv =====
`timescale 1ns / 100ps

module tb_ir_pulse_distance_decoder;
	import ipd_pkg::*;

	localparam logic [CIDX_W-1:0] REG_UNUSED = 8'hFF;
	localparam out_item_t QUIET = '{ST_NONE, 32'd0, 1'b0};

	typedef struct packed {
		in_item_t  req;
		logic      fixed;
		out_item_t want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index;
	logic [TICKS_W-1:0] cfg_data;

	// decoder mirror: tick settings and frame state
	logic [TICKS_W-1:0] start_nom, one_nom, zero_nom, tol_nom;
	logic [EDGE_W-1:0]  last_edge;
	logic               framing;
	int                 nbits;
	logic [WORD_W-1:0]  shreg;
	logic               corrupt;
	logic               held;

	out_item_t due_results[$];
	int        errors;
	int        sent;
	int        results_seen;

	// rows 0..2 straight after reset; the rest walk tolerance edges and the timer wrap
	dir_row_t dir_tab [15] = '{
		'{'{KIND_ACK,  32'hFFFF_FFFF}, 1'b1, QUIET},
		'{'{KIND_EDGE, 32'hFFFF_FFFF}, 1'b1, QUIET},
		'{'{KIND_EDGE, 32'd6799},      1'b1, QUIET},
		'{'{KIND_EDGE, 32'd8588},      1'b0, QUIET},
		'{'{KIND_EDGE, 32'd9339},      1'b0, QUIET},
		'{'{KIND_EDGE, 32'd11129},     1'b0, QUIET},
		'{'{KIND_EDGE, 32'd17830},     1'b0, QUIET},
		'{'{KIND_EDGE, 32'd18780},     1'b0, QUIET},
		'{'{KIND_EDGE, 32'd20370},     1'b0, QUIET},
		'{'{KIND_EDGE, 32'hAAAA_AAAA}, 1'b0, QUIET},
		'{'{KIND_EDGE, 32'h5555_5555}, 1'b0, QUIET},
		'{'{KIND_ACK,  32'h0000_0000}, 1'b0, QUIET},
		'{'{KIND_EDGE, 32'h5555_7049}, 1'b0, QUIET},
		'{'{KIND_EDGE, 32'h5555_8A75}, 1'b0, QUIET},
		'{'{KIND_EDGE, 32'h0000_0000}, 1'b0, QUIET}
	};

	ir_pulse_distance_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb_ir_pulse_distance_decoder: FAIL");
		$finish;
	end

	function automatic logic within_tol(logic [EDGE_W-1:0] gap, logic [TICKS_W-1:0] nom);
		logic [EDGE_W-1:0] dev;
		dev = (gap > nom) ? gap - nom : nom - gap;
		return dev < tol_nom;
	endfunction

	function automatic out_item_t ir_decode_step(in_item_t req);
		out_item_t         r;
		logic [EDGE_W-1:0] gap;
		r = QUIET;
		if (req.kind == KIND_ACK) begin
			held = 1'b0;
		end else if (!held) begin
			gap = req.edge_time - last_edge;
			last_edge = req.edge_time;
			if (within_tol(gap, start_nom)) begin
				framing = 1'b1;
				nbits = 0;
				shreg = '0;
				corrupt = 1'b0;
			end else if (framing && nbits < FRAME_BITS_DEF) begin
				if (within_tol(gap, one_nom))
					shreg = {shreg[WORD_W-2:0], 1'b1};
				else begin
					shreg = {shreg[WORD_W-2:0], 1'b0};
					if (!within_tol(gap, zero_nom))
						corrupt = 1'b1;
				end
				nbits++;
			end else if (framing && nbits == FRAME_BITS_DEF) begin
				framing = 1'b0;
				held = 1'b1;
				nbits = 0;
				if (corrupt) begin
					r.status = ST_BAD;
				end else begin
					r.status = ST_GOOD;
					r.frame_word = shreg;
				end
			end
		end
		r.holding = held;
		return r;
	endfunction

	// interval within tolerance of a nominal, jittered either way
	function automatic logic [EDGE_W-1:0] near_gap(logic [TICKS_W-1:0] nom);
		logic [EDGE_W-1:0] d;
		if (tol_nom == 0)
			return {16'd0, nom};
		d = $urandom_range(int'(tol_nom) - 1);
		if ($urandom_range(1) && d <= nom)
			return nom - d;
		return nom + d;
	endfunction

	task automatic check_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (due_results.size() == 0) begin
			$error("result with no request outstanding: %h", got);
			errors++;
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.frame_word !== want.frame_word) begin
			$error("frame_word: expected %h, got %h", want.frame_word, got.frame_word);
			errors++;
		end
		if (got.holding !== want.holding) begin
			$error("holding: expected %0d, got %0d", want.holding, got.holding);
			errors++;
		end
	endtask

	task automatic offer(in_item_t req, logic fixed, out_item_t want);
		out_item_t got;
		got = ir_decode_step(req);
		due_results.push_back(fixed ? want : got);
		if (sent < 700 || sent >= 900)
			while ($urandom_range(99) < 18) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall === 1'b1);
		sent++;
	endtask

	task automatic send_item(kind_t k, logic [EDGE_W-1:0] t);
		in_item_t req;
		req.kind = k;
		req.edge_time = t;
		offer(req, 1'b0, QUIET);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TICKS_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			REG_START: start_nom = val;
			REG_ONE:   one_nom = val;
			REG_ZERO:  zero_nom = val;
			REG_TOL:   tol_nom = val;
			default: ;
		endcase
	endtask

	task automatic program_ticks(logic [TICKS_W-1:0] s, logic [TICKS_W-1:0] o,
			logic [TICKS_W-1:0] z, logic [TICKS_W-1:0] t);
		write_reg(REG_START, s);
		write_reg(REG_ONE, o);
		write_reg(REG_ZERO, z);
		write_reg(REG_TOL, t);
	endtask

	task automatic send_frame(bit spoil, bit ack_after);
		int                 bad_at;
		logic [TICKS_W-1:0] nom;
		bad_at = spoil ? $urandom_range(FRAME_BITS_DEF - 1) : -1;
		if (held)
			send_item(KIND_ACK, $urandom());
		send_item(KIND_EDGE, last_edge + near_gap(start_nom));
		for (int i = 0; i < FRAME_BITS_DEF; i++) begin
			nom = $urandom_range(1) ? one_nom : zero_nom;
			if (i == bad_at)
				send_item(KIND_EDGE, last_edge + $urandom_range(200000));
			else
				send_item(KIND_EDGE, last_edge + near_gap(nom));
		end
		send_item(KIND_EDGE, last_edge + $urandom_range(30000));
		// edges while held should be dropped
		repeat ($urandom_range(2)) send_item(KIND_EDGE, $urandom());
		if (ack_after)
			send_item(KIND_ACK, $urandom());
	endtask

	task automatic run_random(int quota);
		int stop;
		int pick;
		stop = sent + quota;
		while (sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_frame($urandom_range(99) < 20, $urandom_range(99) < 85);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4))
					send_item(kind_t'($urandom_range(1)), $urandom());
			end else begin
				// truncated frame, left for the next start to restart
				send_item(KIND_EDGE, last_edge + near_gap(start_nom));
				repeat ($urandom_range(1, 31))
					send_item(KIND_EDGE,
						last_edge + near_gap($urandom_range(1) ? one_nom : zero_nom));
			end
		end
	endtask

	// result side: random stall, two long hold-offs, one stall-free stretch
	initial begin
		int hold_left;
		int hold_mark;
		hold_left = 0;
		hold_mark = -1;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				check_result(out_data);
			if (hold_left == 0 && (results_seen == 400 || results_seen == 1100)
					&& hold_mark != results_seen) begin
				hold_mark = results_seen;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= 700 && results_seen < 900) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 18);
			end
		end
	end

	initial begin
		errors = 0;
		sent = 0;
		results_seen = 0;
		start_nom = START_RST;
		one_nom = ONE_RST;
		zero_nom = ZERO_RST;
		tol_nom = TOL_RST;
		last_edge = '0;
		framing = 1'b0;
		nbits = 0;
		shreg = '0;
		corrupt = 1'b0;
		held = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			offer(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want);
		run_random(190);
		drain();

		// exact match only; unused index must change nothing
		program_ticks(16'hFFFF, 16'h0000, 16'h8000, 16'd1);
		write_reg(REG_UNUSED, 16'($urandom()));
		run_random(190);
		drain();

		program_ticks(START_RST, ONE_RST, ZERO_RST, 16'd0);
		run_random(190);
		drain();

		program_ticks(16'h0000, 16'hFFFF, 16'd3000, 16'hFFFF);
		run_random(190);
		drain();

		repeat (4) begin
			program_ticks(16'($urandom_range(2000, 65535)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(1, 4000)));
			run_random(190);
			drain();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_ir_pulse_distance_decoder: PASS");
		else
			$display("tb_ir_pulse_distance_decoder: FAIL");
		$finish;
	end

endmodule
